@@ sv/tlcd_pkg.sv @@
package tlcd_pkg;

  localparam int unsigned MAX_MAP_WIDTH_DEF = 4096;
  localparam int unsigned MAX_ROWS_DEF      = 65536;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CODE_W    = 32;
  localparam int unsigned ID_W      = 29;
  localparam int unsigned PIX_W     = 11;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned POS_X_W   = 22;
  localparam int unsigned POS_Y_W   = 26;
  localparam int unsigned SRC_X_W   = 22;
  localparam int unsigned SRC_Y_W   = 39;
  localparam int unsigned REM_W     = 12;
  localparam int unsigned OUT_RAW_W = ID_W + POS_X_W + POS_Y_W + SRC_X_W + SRC_Y_W + 1;
  localparam int unsigned OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [PIX_W-1:0]   MAX_TILE_PIXELS = PIX_W'(1024);
  localparam logic [COUNT_W-1:0] MAX_COLUMNS     = COUNT_W'(4096);

  localparam logic [CODE_W-1:0] CODE_FLIP_H  = 32'h8000_0000;
  localparam logic [CODE_W-1:0] CODE_FLIP_V  = 32'h4000_0000;
  localparam logic [CODE_W-1:0] CODE_FLIP_D  = 32'h2000_0000;
  localparam logic [CODE_W-1:0] CODE_ID_MASK = ~(CODE_FLIP_H | CODE_FLIP_V | CODE_FLIP_D);

  localparam logic [CHAR_W-1:0] CHAR_END  = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = COUNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_WIDTH      = 2'd0,
    CFG_TILE_HEIGHT     = 2'd1,
    CFG_MAP_WIDTH       = 2'd2,
    CFG_TILESET_COLUMNS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0]   tile_width;
    logic [PIX_W-1:0]   tile_height;
    logic [COUNT_W-1:0] map_width;
    logic [COUNT_W-1:0] tileset_columns;
  } cfg_t;

  localparam logic [PIX_W-1:0]   TILE_WIDTH_RST      = PIX_W'(16);
  localparam logic [PIX_W-1:0]   TILE_HEIGHT_RST     = PIX_W'(16);
  localparam logic [COUNT_W-1:0] MAP_WIDTH_RST       = COUNT_W'(64);
  localparam logic [COUNT_W-1:0] TILESET_COLUMNS_RST = COUNT_W'(16);

endpackage

@@ sv/tlcd_front.sv @@
module tlcd_front
  import tlcd_pkg::*;
#(
  parameter int unsigned MAX_MAP_WIDTH = MAX_MAP_WIDTH_DEF,
  parameter int unsigned MAX_ROWS      = MAX_ROWS_DEF,
  localparam int unsigned COL_W = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1,
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic [CHAR_W-1:0] byte_i,
  output logic              byte_ready_o,
  input  logic [COUNT_W-1:0] map_width_i,
  input  logic              job_full_i,
  output logic              job_push_o,
  output logic [ID_W-1:0]   job_id_o,
  output logic              job_flip_o,
  output logic [COL_W-1:0]  job_col_o,
  output logic [ROW_W-1:0]  job_row_o
);

  localparam int unsigned WCMP_W = ($clog2(MAX_MAP_WIDTH + 1) > COUNT_W) ?
                                   $clog2(MAX_MAP_WIDTH + 1) : COUNT_W;
  localparam int unsigned RCMP_W = $clog2(MAX_ROWS + 1);

  logic [CODE_W-1:0] accum_q, accum_d;
  logic              ovf_q, ovf_d;
  logic              have_q, have_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;

  logic                accept;
  logic                is_digit;
  logic [CODE_W+3:0]   next_accum;
  logic [CODE_W-1:0]   id_code;
  logic [WCMP_W-1:0]   row_len;
  logic [WCMP_W-1:0]   col_inc;
  logic [RCMP_W-1:0]   row_inc;

  assign byte_ready_o = !job_full_i;
  assign accept       = byte_valid_i && !job_full_i;
  assign is_digit     = byte_i inside {[CHAR_ZERO:CHAR_NINE]};

  assign next_accum = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1)
                    + (CODE_W + 4)'(byte_i[3:0]);
  assign id_code    = accum_q & CODE_ID_MASK;

  always_comb begin
    if (map_width_i == '0) begin
      row_len = WCMP_W'(1);
    end else if (WCMP_W'(map_width_i) > WCMP_W'(MAX_MAP_WIDTH)) begin
      row_len = WCMP_W'(MAX_MAP_WIDTH);
    end else begin
      row_len = WCMP_W'(map_width_i);
    end
  end

  assign col_inc = WCMP_W'(col_q) + WCMP_W'(1);
  assign row_inc = RCMP_W'(row_q) + RCMP_W'(1);

  assign job_id_o   = id_code[ID_W-1:0];
  assign job_flip_o = |(accum_q & CODE_FLIP_H);
  assign job_col_o  = col_q;
  assign job_row_o  = row_q;

  always_comb begin
    accum_d    = accum_q;
    ovf_d      = ovf_q;
    have_d     = have_q;
    col_d      = col_q;
    row_d      = row_q;
    job_push_o = 1'b0;
    if (accept) begin
      if (byte_i == CHAR_END) begin
        accum_d = '0;
        ovf_d   = 1'b0;
        have_d  = 1'b0;
        col_d   = '0;
        row_d   = '0;
      end else if (is_digit) begin
        accum_d = next_accum[CODE_W-1:0];
        ovf_d   = ovf_q || (next_accum[CODE_W+3:CODE_W] != '0);
        have_d  = 1'b1;
      end else if (have_q) begin
        // a finished number always advances the index, even with no tile
        job_push_o = !ovf_q && (id_code != '0);
        accum_d    = '0;
        ovf_d      = 1'b0;
        have_d     = 1'b0;
        if (col_inc >= row_len) begin
          col_d = '0;
          if (row_inc >= RCMP_W'(MAX_ROWS)) begin
            row_d = '0;
          end else begin
            row_d = row_inc[ROW_W-1:0];
          end
        end else begin
          col_d = col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q <= '0;
      ovf_q   <= 1'b0;
      have_q  <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      accum_q <= accum_d;
      ovf_q   <= ovf_d;
      have_q  <= have_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

@@ sv/tlcd_queue.sv @@
module tlcd_queue
  import tlcd_pkg::*;
#(
  parameter int unsigned DATA_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/tlcd_back.sv @@
module tlcd_back
  import tlcd_pkg::*;
#(
  parameter int unsigned MAX_MAP_WIDTH = MAX_MAP_WIDTH_DEF,
  parameter int unsigned MAX_ROWS      = MAX_ROWS_DEF,
  localparam int unsigned COL_W = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1,
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               job_valid_i,
  output logic               job_pop_o,
  input  logic [ID_W-1:0]    job_id_i,
  input  logic               job_flip_i,
  input  logic [COL_W-1:0]   job_col_i,
  input  logic [ROW_W-1:0]   job_row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ID_W-1:0]    tile_id_o,
  output logic [POS_X_W-1:0] pos_x_o,
  output logic [POS_Y_W-1:0] pos_y_o,
  output logic [SRC_X_W-1:0] src_x_o,
  output logic [SRC_Y_W-1:0] src_y_o,
  output logic               hflip_o
);

  localparam int unsigned STEP_W = $clog2(ID_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_MUL  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [ID_W-1:0]   quo_q, quo_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ID_W-1:0]   id_q;
  logic              flip_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic              load_job;

  logic              out_valid_q, out_valid_d;
  logic              load_out;

  logic [PIX_W-1:0]   tw;
  logic [PIX_W-1:0]   th;
  logic [COUNT_W-1:0] cols;
  logic [REM_W:0]     rem_sh;
  logic               rem_fit;

  logic [COL_W+PIX_W-1:0] pos_x_full;
  logic [ROW_W+PIX_W-1:0] pos_y_full;
  logic [REM_W+PIX_W-1:0] src_x_full;
  logic [ID_W+PIX_W-1:0]  src_y_full;

  assign tw = (cfg_i.tile_width > MAX_TILE_PIXELS) ? MAX_TILE_PIXELS : cfg_i.tile_width;
  assign th = (cfg_i.tile_height > MAX_TILE_PIXELS) ? MAX_TILE_PIXELS : cfg_i.tile_height;

  always_comb begin
    if (cfg_i.tileset_columns == '0) begin
      cols = COUNT_W'(1);
    end else if (cfg_i.tileset_columns > MAX_COLUMNS) begin
      cols = MAX_COLUMNS;
    end else begin
      cols = cfg_i.tileset_columns;
    end
  end

  // restoring division of (id - 1) by the column count, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[ID_W-1]};
  assign rem_fit = (rem_sh >= (REM_W + 1)'(cols));

  assign load_out  = (state_q == ST_MUL) && (!out_valid_q || out_ready_i);
  assign load_job  = (state_q == ST_IDLE) && job_valid_i;
  assign job_pop_o = load_job;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          quo_d   = job_id_i - ID_W'(1);
          rem_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_fit) begin
          rem_d = REM_W'(rem_sh - (REM_W + 1)'(cols));
        end else begin
          rem_d = rem_sh[REM_W-1:0];
        end
        quo_d  = {quo_q[ID_W-2:0], rem_fit};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ID_W - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign pos_x_full = (COL_W + PIX_W)'(col_q) * (COL_W + PIX_W)'(tw);
  assign pos_y_full = (ROW_W + PIX_W)'(row_q) * (ROW_W + PIX_W)'(th);
  assign src_x_full = (REM_W + PIX_W)'(rem_q) * (REM_W + PIX_W)'(tw);
  assign src_y_full = (ID_W + PIX_W)'(quo_q) * (ID_W + PIX_W)'(th);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (load_job) begin
      id_q   <= job_id_i;
      flip_q <= job_flip_i;
      col_q  <= job_col_i;
      row_q  <= job_row_i;
    end
    if (load_out) begin
      tile_id_o <= id_q;
      pos_x_o   <= POS_X_W'(pos_x_full);
      pos_y_o   <= POS_Y_W'(pos_y_full);
      src_x_o   <= SRC_X_W'(src_x_full);
      src_y_o   <= SRC_Y_W'(src_y_full);
      hflip_o   <= flip_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/tile_layer_csv_decoder.sv @@
// Throughput: one text byte per cycle while the job queue has room; the back end's
// bit-serial divider (29 steps plus load and multiply) works on one job at a time and
// takes the next only once the last tile has been loaded into the output registers.
// Reset (asynchronous, active low) clears the number, the tile index, the queue and
// the output, and sets the registers to 16, 16, 64 and 16.
module tile_layer_csv_decoder
  import tlcd_pkg::*;
#(
  parameter int unsigned MAX_MAP_WIDTH = MAX_MAP_WIDTH_DEF,
  parameter int unsigned MAX_ROWS      = MAX_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_code
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [28:0] tile_id, [50:29] pos_x, [76:51] pos_y, [98:77] src_x,
  // [137:99] src_y, [138] hflip, rest zero
  output logic [OUT_W-1:0]      m_axis_tdata
);

  localparam int unsigned COL_W = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;
  localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned JOB_W = ID_W + 1 + COL_W + ROW_W;

  cfg_t cfg_q;

  logic              push;
  logic              full;
  logic              pop;
  logic              empty;
  logic [ID_W-1:0]   f_id;
  logic              f_flip;
  logic [COL_W-1:0]  f_col;
  logic [ROW_W-1:0]  f_row;
  logic [JOB_W-1:0]  push_data;
  logic [JOB_W-1:0]  pop_data;

  logic [ID_W-1:0]    tile_id;
  logic [POS_X_W-1:0] pos_x;
  logic [POS_Y_W-1:0] pos_y;
  logic [SRC_X_W-1:0] src_x;
  logic [SRC_Y_W-1:0] src_y;
  logic               hflip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tile_width      <= TILE_WIDTH_RST;
      cfg_q.tile_height     <= TILE_HEIGHT_RST;
      cfg_q.map_width       <= MAP_WIDTH_RST;
      cfg_q.tileset_columns <= TILESET_COLUMNS_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TILE_WIDTH:      cfg_q.tile_width      <= cfg_wdata_i[PIX_W-1:0];
        CFG_TILE_HEIGHT:     cfg_q.tile_height     <= cfg_wdata_i[PIX_W-1:0];
        CFG_MAP_WIDTH:       cfg_q.map_width       <= cfg_wdata_i;
        CFG_TILESET_COLUMNS: cfg_q.tileset_columns <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  tlcd_front #(
    .MAX_MAP_WIDTH(MAX_MAP_WIDTH),
    .MAX_ROWS     (MAX_ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(s_axis_tvalid),
    .byte_i      (s_axis_tdata),
    .byte_ready_o(s_axis_tready),
    .map_width_i (cfg_q.map_width),
    .job_full_i  (full),
    .job_push_o  (push),
    .job_id_o    (f_id),
    .job_flip_o  (f_flip),
    .job_col_o   (f_col),
    .job_row_o   (f_row)
  );

  assign push_data = {f_row, f_col, f_flip, f_id};

  tlcd_queue #(
    .DATA_W(JOB_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  tlcd_back #(
    .MAX_MAP_WIDTH(MAX_MAP_WIDTH),
    .MAX_ROWS     (MAX_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .job_valid_i(!empty),
    .job_pop_o  (pop),
    .job_id_i   (pop_data[ID_W-1:0]),
    .job_flip_i (pop_data[ID_W]),
    .job_col_i  (pop_data[ID_W+COL_W:ID_W+1]),
    .job_row_i  (pop_data[JOB_W-1:ID_W+COL_W+1]),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .tile_id_o  (tile_id),
    .pos_x_o    (pos_x),
    .pos_y_o    (pos_y),
    .src_x_o    (src_x),
    .src_y_o    (src_y),
    .hflip_o    (hflip)
  );

  assign m_axis_tdata = OUT_W'({hflip, src_y, src_x, pos_y, pos_x, tile_id});

endmodule

@@ dv/tb_tile_layer_csv_decoder.sv @@
`timescale 1ns / 100ps

module tb_tile_layer_csv_decoder;
  import tlcd_pkg::*;

  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DIR_N        = 26;

  // same layout as m_axis_tdata, last field in the lowest bits
  typedef struct packed {
    logic               hflip;
    logic [SRC_Y_W-1:0] src_y;
    logic [SRC_X_W-1:0] src_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [POS_X_W-1:0] pos_x;
    logic [ID_W-1:0]    tile_id;
  } tile_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              typed;
    tile_t             res;
  } text_row_t;

  typedef enum {
    KIND_ZERO, KIND_MAX, KIND_RANDOM, KIND_OVERFLOW, KIND_FLIPPED, KIND_FLIP_ONLY, KIND_SMALL
  } code_kind_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [CHAR_W-1:0]     s_axis_tdata = '0;    // [7:0] char_code
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [28:0] tile_id, [50:29] pos_x, [76:51] pos_y, [98:77] src_x,
  // [137:99] src_y, [138] hflip, rest zero
  logic [OUT_W-1:0]      m_axis_tdata;

  tile_layer_csv_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // decoder state as predicted
  logic [PIX_W-1:0]   tw_q = TILE_WIDTH_RST;
  logic [PIX_W-1:0]   th_q = TILE_HEIGHT_RST;
  logic [COUNT_W-1:0] mw_q = MAP_WIDTH_RST;
  logic [COUNT_W-1:0] tc_q = TILESET_COLUMNS_RST;
  logic [CODE_W-1:0]  accum_q = '0;
  bit                 overflow_q = 1'b0;
  bit                 digits_q = 1'b0;
  int unsigned        col_q = 0;
  int unsigned        row_q = 0;

  tile_t             tile_q [$];
  logic [CHAR_W-1:0] text_q [$];
  int                err_count = 0;
  int unsigned       cycle_cnt = 0;
  int                hold_asked = 0;
  int                hold_served = 0;
  int                tx_draws = 0;
  bit                tx_calm = 1'b0;
  int                rx_draws = 0;
  bit                rx_calm = 1'b0;

  // carried with each byte so the monitor knows a typed-in expectation
  logic  row_typed = 1'b0;
  tile_t row_tile = '0;
  tile_t pred_tile;
  bit    pred_hit;
  tile_t seen_tile;
  tile_t want_tile;

  text_row_t dir_tab [DIR_N] = '{
    '{"1", 1'b0, '0},
    '{",", 1'b1, '{tile_id: ID_W'(1), default: '0}},
    '{"0", 1'b0, '0},
    '{",", 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{"0", 1'b0, '0},
    '{"0", 1'b0, '0},
    '{"7", 1'b0, '0},
    '{8'h80, 1'b0, '0},
    // 2**32: one past the largest code
    '{"4", 1'b0, '0},
    '{"2", 1'b0, '0},
    '{"9", 1'b0, '0},
    '{"4", 1'b0, '0},
    '{"9", 1'b0, '0},
    '{"6", 1'b0, '0},
    '{"7", 1'b0, '0},
    '{"2", 1'b0, '0},
    '{"9", 1'b0, '0},
    '{"6", 1'b0, '0},
    '{"/", 1'b0, '0},
    '{"2", 1'b0, '0},
    '{":", 1'b0, '0},
    '{"3", 1'b0, '0},
    '{CHAR_END, 1'b0, '0},
    '{"5", 1'b0, '0},
    '{" ", 1'b1, '{tile_id: ID_W'(5), src_x: SRC_X_W'(64), default: '0}}
  };

  function automatic longint unsigned px_limit(input logic [PIX_W-1:0] v);
    return (v > MAX_TILE_PIXELS) ? longint'(MAX_TILE_PIXELS) : longint'(v);
  endfunction

  function automatic int unsigned count_limit(input logic [COUNT_W-1:0] v,
                                              input int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : int'(v);
  endfunction

  function automatic bit decode_char(input logic [CHAR_W-1:0] ch, output tile_t t);
    longint unsigned nxt;
    longint unsigned tw;
    longint unsigned th;
    int unsigned     id;
    int unsigned     k;
    int unsigned     cols;
    bit              hit;
    hit = 1'b0;
    t = '0;
    if (ch == CHAR_END) begin
      accum_q = '0;
      overflow_q = 1'b0;
      digits_q = 1'b0;
      col_q = 0;
      row_q = 0;
      return 1'b0;
    end
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      nxt = longint'(accum_q) * 10 + longint'(ch - CHAR_ZERO);
      if (nxt > 64'hFFFF_FFFF) overflow_q = 1'b1;
      accum_q = nxt[CODE_W-1:0];
      digits_q = 1'b1;
      return 1'b0;
    end
    if (!digits_q) return 1'b0;
    if (!overflow_q) begin
      id = accum_q & CODE_ID_MASK;
      if (id != 0) begin
        tw = px_limit(tw_q);
        th = px_limit(th_q);
        cols = count_limit(tc_q, MAX_COLUMNS);
        k = id - 1;
        t.tile_id = ID_W'(id);
        t.pos_x = POS_X_W'(col_q * tw);
        t.pos_y = POS_Y_W'(row_q * th);
        t.src_x = SRC_X_W'((k % cols) * tw);
        t.src_y = SRC_Y_W'((k / cols) * th);
        t.hflip = (accum_q & CODE_FLIP_H) != 0;
        hit = 1'b1;
      end
    end
    accum_q = '0;
    overflow_q = 1'b0;
    digits_q = 1'b0;
    // a column left beyond a narrowed map wraps here
    col_q++;
    if (col_q >= count_limit(mw_q, MAX_MAP_WIDTH_DEF)) begin
      col_q = 0;
      row_q++;
      if (row_q >= MAX_ROWS_DEF) row_q = 0;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic draw_gap(inout int draws, inout bit calm, output int gap);
    if (draws % 40 == 0) calm = ($urandom_range(0, 3) == 0);
    draws++;
    gap = calm ? 0 : $urandom_range(0, 4);
  endtask

  task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic typed, input tile_t res);
    int gap;
    draw_gap(tx_draws, tx_calm, gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    row_typed     <= typed;
    row_tile      <= res;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tile_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] tw, input logic [CFG_DATA_W-1:0] th,
                            input logic [CFG_DATA_W-1:0] mw, input logic [CFG_DATA_W-1:0] tc);
    logic [CFG_DATA_W-1:0] val [4];
    val = '{tw, th, mw, tc};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      case (cfg_reg_e'(i))
        CFG_TILE_WIDTH:      tw_q = val[i][PIX_W-1:0];
        CFG_TILE_HEIGHT:     th_q = val[i][PIX_W-1:0];
        CFG_MAP_WIDTH:       mw_q = val[i];
        CFG_TILESET_COLUMNS: tc_q = val[i];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] pick_separator();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 2) != 0) return ",";
    do c = CHAR_W'($urandom_range(1, 255)); while (c >= CHAR_ZERO && c <= CHAR_NINE);
    return c;
  endfunction

  // queue one chunk of layer text: mostly a code plus separator, some noise
  task automatic make_sequence();
    int          r;
    int          nd;
    int          dig [$];
    code_kind_e  kind;
    logic [31:0] code;
    longint unsigned v;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      text_q.push_back(CHAR_END);
      return;
    end
    if (r < 12) begin
      text_q.push_back(CHAR_W'($urandom_range(0, 255)));
      return;
    end
    kind = ($urandom_range(0, 9) > 6) ? KIND_SMALL : code_kind_e'($urandom_range(0, 6));
    case (kind)
      KIND_ZERO:      code = '0;
      KIND_MAX:       code = 32'hFFFF_FFFF;
      KIND_RANDOM:    code = $urandom();
      KIND_FLIPPED:   code = {3'($urandom_range(0, 7)), 29'($urandom_range(1, 5000))};
      KIND_FLIP_ONLY: code = {3'($urandom_range(1, 7)), 29'd0};
      default:        code = $urandom_range(1, 300);
    endcase
    if (kind == KIND_OVERFLOW) begin
      // ten digits from 5e9 up, or more digits, all above 32 bits
      nd = $urandom_range(10, 12);
      dig.push_back((nd == 10) ? $urandom_range(5, 9) : $urandom_range(1, 9));
      repeat (nd - 1) dig.push_back($urandom_range(0, 9));
    end else begin
      v = 64'(code);
      do begin
        dig.push_front(int'(v % 10));
        v = v / 10;
      end while (v != 0);
    end
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) text_q.push_back(CHAR_ZERO);
    foreach (dig[i]) text_q.push_back(CHAR_ZERO + CHAR_W'(dig[i]));
    // broken: end the layer in the middle of a number
    if (r < 16) begin
      text_q.push_back(CHAR_END);
      return;
    end
    text_q.push_back(pick_separator());
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) text_q.push_back(pick_separator());
  endtask

  // predict on every input transaction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pred_hit = decode_char(s_axis_tdata, pred_tile);
      if (row_typed) tile_q.push_back(row_tile);
      else if (pred_hit) tile_q.push_back(pred_tile);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_tile = tile_t'(m_axis_tdata[OUT_RAW_W-1:0]);
      if (tile_q.size() == 0) begin
        report_mismatch("tile with none pending, tile_id", seen_tile.tile_id, '0);
      end else begin
        want_tile = tile_q.pop_front();
        check_field("tile_id", seen_tile.tile_id, want_tile.tile_id);
        check_field("pos_x", seen_tile.pos_x, want_tile.pos_x);
        check_field("pos_y", seen_tile.pos_y, want_tile.pos_y);
        check_field("src_x", seen_tile.src_x, want_tile.src_x);
        check_field("src_y", seen_tile.src_y, want_tile.src_y);
        check_field("hflip", seen_tile.hflip, want_tile.hflip);
      end
    end
  end

  initial begin : receiver
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_served != hold_asked) begin
        // hold off long enough for the job queue to fill and stall the input
        hold_served++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      draw_gap(rx_draws, rx_calm, stall);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid && hold_served == hold_asked);
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[tile_layer_csv_decoder] ERROR");
    $finish;
  end

  initial begin : stimulus
    int sent;
    logic [CFG_DATA_W-1:0] tw, th, mw, tc;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_N; i++) send_byte(dir_tab[i].ch, dir_tab[i].typed, dir_tab[i].res);

    // the tile index carries across phases, so width changes land mid-layer
    for (int p = 1; p <= PHASES; p++) begin
      wait_drain();
      case (p)
        1: begin tw = 1; th = 1; mw = 1; tc = 1; end
        2: begin tw = 1024; th = 1024; mw = 4096; tc = 4096; end
        3: begin tw = 0; th = 0; mw = 0; tc = 0; end
        4: begin tw = 13'h1FFF; th = 13'h07FF; mw = 13'h1FFF; tc = 13'h1FFF; end
        5, 6: begin
          tw = CFG_DATA_W'($urandom_range(0, 8191));
          th = CFG_DATA_W'($urandom_range(0, 8191));
          mw = CFG_DATA_W'($urandom_range(0, 8191));
          tc = CFG_DATA_W'($urandom_range(0, 8191));
        end
        default: begin
          tw = CFG_DATA_W'($urandom_range(1, 1024));
          th = CFG_DATA_W'($urandom_range(1, 1024));
          mw = CFG_DATA_W'($urandom_range(1, 12));
          tc = CFG_DATA_W'($urandom_range(1, 4096));
        end
      endcase
      set_config(tw, th, mw, tc);
      if (p == 1) hold_asked++;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        make_sequence();
        while (text_q.size() != 0) begin
          send_byte(text_q.pop_front(), 1'b0, '0);
          sent++;
        end
      end
    end

    wait_drain();
    if (err_count == 0) begin
      $display("[tile_layer_csv_decoder] OK");
    end else begin
      $display("[tile_layer_csv_decoder] ERROR");
    end
    $finish;
  end

endmodule
